[src/radar_measurement_jacobian_assert.svh]
// ----------------------------------------------------------------------------
// Radar measurement Jacobian assertion macros
// Shared property shorthands; clk and rst are taken from the including module.
// ----------------------------------------------------------------------------
`ifndef RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMJ_ASSERT_IMPLY(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMJ_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

[src/ramj_pkg.sv]
// ----------------------------------------------------------------------------
// Radar measurement Jacobian package
// Register map and queue sizing shared by the front end and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ramj_pkg;

  localparam int unsigned CFG_DATA_WIDTH = 32;
  localparam int unsigned CFG_ADDR_WIDTH = 3;
  localparam int unsigned CFG_INDEX_WIDTH = CFG_ADDR_WIDTH - 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NEAR_ZERO_LIMIT = 1'b0;
  localparam logic [CFG_DATA_WIDTH-1:0] NEAR_ZERO_LIMIT_RESET = 32'd429497;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned MID_COUNT_WIDTH = $clog2(MID_DEPTH + 1);
  localparam int unsigned OUT_DEPTH = 2;

endpackage

[src/ramj_fifo.sv]
// ----------------------------------------------------------------------------
// Radar measurement Jacobian queue
// Small first-in first-out buffer with an occupancy count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radar_measurement_jacobian_assert.svh"

module ramj_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic                           full,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             wr;
  logic             rd;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RMJ_ASSERT_IMPLY(a_no_overflow, push, !full, "item pushed into a full queue")
  `RMJ_ASSERT_NEXT(a_push_lands, push, count != '0, "pushed item did not land")

endmodule

[src/ramj_front.sv]
// ----------------------------------------------------------------------------
// Radar measurement Jacobian front end
// Takes items, forms magnitudes, squared range and the rate cross term, and
// classifies near-zero positions before handing items to the middle queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ramj_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [DATA_WIDTH-1:0]          pos_x,
  input  logic signed [DATA_WIDTH-1:0]          pos_y,
  input  logic signed [DATA_WIDTH-1:0]          vel_x,
  input  logic signed [DATA_WIDTH-1:0]          vel_y,
  input  logic [ramj_pkg::CFG_DATA_WIDTH-1:0]   limit,
  input  logic [ramj_pkg::MID_COUNT_WIDTH-1:0]  q_count,
  output logic                                  q_push,
  output logic [6*DATA_WIDTH+3:0]               q_data
);

  import ramj_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned MW = 2 * DATA_WIDTH;
  localparam int unsigned SW = MID_COUNT_WIDTH + 1;

  logic [W-1:0]  ax, ay, avx, avy;
  logic          acc;

  logic          v1;
  logic [W-1:0]  mx1, my1, mvx1, mvy1;
  logic          nx1, ny1, nvx1, nvy1;

  logic          v2;
  logic [MW-1:0] sx2, sy2, p1_2, p2_2;
  logic [W-1:0]  mx2, my2;
  logic          nx2, ny2, n1_2, n2_2;

  logic [MW-1:0] s;
  logic [MW-1:0] dm;
  logic          nd;
  logic          degen;

  assign ax  = pos_x[W-1] ? W'(~pos_x + 1'b1) : W'(pos_x);
  assign ay  = pos_y[W-1] ? W'(~pos_y + 1'b1) : W'(pos_y);
  assign avx = vel_x[W-1] ? W'(~vel_x + 1'b1) : W'(vel_x);
  assign avy = vel_y[W-1] ? W'(~vel_y + 1'b1) : W'(vel_y);

  assign full = (SW'(q_count) + SW'(v1) + SW'(v2)) >= SW'(MID_DEPTH);
  assign acc  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mx1  <= ax;
    my1  <= ay;
    mvx1 <= avx;
    mvy1 <= avy;
    nx1  <= pos_x[W-1];
    ny1  <= pos_y[W-1];
    nvx1 <= vel_x[W-1];
    nvy1 <= vel_y[W-1];
  end

  always_ff @(posedge clk) begin
    sx2  <= mx1 * mx1;
    sy2  <= my1 * my1;
    p1_2 <= mvx1 * my1;
    p2_2 <= mvy1 * mx1;
    mx2  <= mx1;
    my2  <= my1;
    nx2  <= nx1;
    ny2  <= ny1;
    n1_2 <= nvx1 ^ ny1;
    n2_2 <= !(nvy1 ^ nx1);
  end

  always_comb begin
    s     = sx2 + sy2;
    degen = (s < MW'(limit)) || (s == '0);
    priority if (n1_2 == n2_2) begin
      dm = p1_2 + p2_2;
      nd = n1_2;
    end else if (p1_2 >= p2_2) begin
      dm = p1_2 - p2_2;
      nd = n1_2;
    end else begin
      dm = p2_2 - p1_2;
      nd = n2_2;
    end
  end

  assign q_push = v2;
  assign q_data = {degen, nd, ny2, nx2, dm, s, my2, mx2};

endmodule

[src/ramj_div.sv]
// ----------------------------------------------------------------------------
// Radar measurement Jacobian divider
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ramj_div #(
  parameter int unsigned QW = 32,
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          over
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned XW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] lo  [QW];
  logic [DW-1:0] dn  [QW];
  logic [QW-1:0] qb  [QW+1];
  logic          ov  [QW+1];

  logic [HW-1:0] hi;
  logic          hi_ge;

  assign hi    = num[NW-1:QW];
  assign hi_ge = XW'(hi) >= XW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi_ge ? '0 : DW'(hi);
      lo[0]  <= num[QW-1:0];
      dn[0]  <= den;
      qb[0]  <= '0;
      ov[0]  <= hi_ge;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [DW:0] rsh;
    logic        ge;

    assign rsh = {rem[j-1], lo[j-1][QW-j]};
    assign ge  = rsh >= {1'b0, dn[j-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        qb[j] <= {qb[j-1][QW-2:0], ge};
        ov[j] <= ov[j-1];
      end
    end

    if (j < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= ge ? DW'(rsh - {1'b0, dn[j-1]}) : DW'(rsh);
          lo[j]  <= lo[j-1];
          dn[j]  <= dn[j-1];
        end
      end
    end
  end

  assign quo  = qb[QW];
  assign over = ov[QW];

endmodule

[src/ramj_back.sv]
// ----------------------------------------------------------------------------
// Radar measurement Jacobian back end
// Square root, range-cubed and numerator products, six parallel dividers and
// saturation; the whole pipeline advances while the result queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ramj_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  logic [6*DATA_WIDTH+3:0]   q_data,
  output logic                      q_pop,
  input  logic                      o_full,
  output logic                      o_push,
  output logic [6*DATA_WIDTH:0]     o_data
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned MW = 2 * W;
  localparam int unsigned TW = 3 * W;
  localparam int unsigned PW = 6 * W + 4;
  localparam int unsigned NS = 2 * W + 3;

  localparam int unsigned MX_LO = 0;
  localparam int unsigned MY_LO = W;
  localparam int unsigned S_LO  = 2 * W;
  localparam int unsigned DM_LO = 4 * W;
  localparam int unsigned NX_B  = 6 * W;
  localparam int unsigned NY_B  = 6 * W + 1;
  localparam int unsigned ND_B  = 6 * W + 2;
  localparam int unsigned DG_B  = 6 * W + 3;

  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] emit(input logic [W-1:0] q, input logic ov,
                                        input logic neg);
    logic [W-1:0] v;
    if (neg) begin
      v = (ov || (q > LIM_NEG)) ? LIM_NEG : q;
      return W'(~v + 1'b1);
    end else begin
      v = (ov || (q > LIM_POS)) ? LIM_POS : q;
      return v;
    end
  endfunction

  logic [NS-1:0] vld;
  logic          adv;

  logic [PW-1:0] sq_pay  [W];
  logic [W+1:0]  sq_rem  [W];
  logic [W-1:0]  sq_root [W];

  logic [PW-1:0] last_pay;
  logic [W-1:0]  c1;

  logic [MW-1:0] m1_sl, m1_sh, m1_yl, m1_yh, m1_xl, m1_xh;
  logic [W-1:0]  m1_c1, m1_mx, m1_my;
  logic [MW-1:0] m1_s;
  logic [3:0]    m1_sig;

  logic [TW-1:0] m2_c2, m2_ny, m2_nx;
  logic [W-1:0]  m2_c1, m2_mx, m2_my;
  logic [MW-1:0] m2_s;
  logic [3:0]    m2_sig;

  logic [3:0]    dv_sig [W+1];

  logic [W-1:0]  q_rx, q_ry, q_bx, q_by, q_tx, q_ty;
  logic          o_rx, o_ry, o_bx, o_by, o_tx, o_ty;
  logic          fx, fy, fd, fg;

  assign adv    = !vld[NS-1] || !o_full;
  assign q_pop  = adv && !q_empty;
  assign o_push = adv && vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], !q_empty};
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic [PW-1:0] pin;
    logic [W+1:0]  rin;
    logic [W-1:0]  oin;
    logic [MW-1:0] sv;
    logic [W+1:0]  rsh;
    logic [W+1:0]  trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign pin = q_data;
      assign rin = '0;
      assign oin = '0;
    end else begin : g_next
      assign pin = sq_pay[k-1];
      assign rin = sq_rem[k-1];
      assign oin = sq_root[k-1];
    end

    assign sv    = pin[S_LO +: MW];
    assign rsh   = {rin[W-1:0], sv[MW-1-2*k -: 2]};
    assign trial = {oin, 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_pay[k]  <= pin;
        sq_rem[k]  <= ge ? rsh - trial : rsh;
        sq_root[k] <= {oin[W-2:0], ge};
      end
    end
  end

  assign last_pay = sq_pay[W-1];
  assign c1       = sq_root[W-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sl  <= last_pay[S_LO +: W] * c1;
      m1_sh  <= last_pay[S_LO+W +: W] * c1;
      m1_yl  <= last_pay[MY_LO +: W] * last_pay[DM_LO +: W];
      m1_yh  <= last_pay[MY_LO +: W] * last_pay[DM_LO+W +: W];
      m1_xl  <= last_pay[MX_LO +: W] * last_pay[DM_LO +: W];
      m1_xh  <= last_pay[MX_LO +: W] * last_pay[DM_LO+W +: W];
      m1_c1  <= c1;
      m1_mx  <= last_pay[MX_LO +: W];
      m1_my  <= last_pay[MY_LO +: W];
      m1_s   <= last_pay[S_LO +: MW];
      m1_sig <= {last_pay[DG_B], last_pay[ND_B], last_pay[NY_B], last_pay[NX_B]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_c2  <= TW'({m1_sh, {W{1'b0}}}) + TW'(m1_sl);
      m2_ny  <= TW'({m1_yh, {W{1'b0}}}) + TW'(m1_yl);
      m2_nx  <= TW'({m1_xh, {W{1'b0}}}) + TW'(m1_xl);
      m2_c1  <= m1_c1;
      m2_mx  <= m1_mx;
      m2_my  <= m1_my;
      m2_s   <= m1_s;
      m2_sig <= m1_sig;
    end
  end

  ramj_div #(.QW(W), .NW(W + F), .DW(W)) u_div_rx (
    .clk(clk), .en(adv), .num({m2_mx, {F{1'b0}}}), .den(m2_c1),
    .quo(q_rx), .over(o_rx)
  );

  ramj_div #(.QW(W), .NW(W + F), .DW(W)) u_div_ry (
    .clk(clk), .en(adv), .num({m2_my, {F{1'b0}}}), .den(m2_c1),
    .quo(q_ry), .over(o_ry)
  );

  ramj_div #(.QW(W), .NW(W + 2 * F), .DW(MW)) u_div_bx (
    .clk(clk), .en(adv), .num({m2_my, {(2*F){1'b0}}}), .den(m2_s),
    .quo(q_bx), .over(o_bx)
  );

  ramj_div #(.QW(W), .NW(W + 2 * F), .DW(MW)) u_div_by (
    .clk(clk), .en(adv), .num({m2_mx, {(2*F){1'b0}}}), .den(m2_s),
    .quo(q_by), .over(o_by)
  );

  ramj_div #(.QW(W), .NW(TW + F), .DW(TW)) u_div_tx (
    .clk(clk), .en(adv), .num({m2_ny, {F{1'b0}}}), .den(m2_c2),
    .quo(q_tx), .over(o_tx)
  );

  ramj_div #(.QW(W), .NW(TW + F), .DW(TW)) u_div_ty (
    .clk(clk), .en(adv), .num({m2_nx, {F{1'b0}}}), .den(m2_c2),
    .quo(q_ty), .over(o_ty)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_sig[0] <= m2_sig;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_sig
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sig[j] <= dv_sig[j-1];
      end
    end
  end

  assign fx = dv_sig[W][0];
  assign fy = dv_sig[W][1];
  assign fd = dv_sig[W][2];
  assign fg = dv_sig[W][3];

  always_comb begin
    if (fg) begin
      o_data = {1'b1, {(6*W){1'b0}}};
    end else begin
      o_data = {1'b0,
                emit(q_ty, o_ty, fx ^ !fd),
                emit(q_tx, o_tx, fy ^ fd),
                emit(q_by, o_by, fx),
                emit(q_bx, o_bx, !fy),
                emit(q_ry, o_ry, fy),
                emit(q_rx, o_rx, fx)};
    end
  end

endmodule

[src/radar_measurement_jacobian.sv]
// ----------------------------------------------------------------------------
// Radar measurement Jacobian
// Fixed-point polar radar Jacobian entries from a 2-D position and velocity.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the front-end registers, the middle queue, the
// back-end pipeline and the result queue; results that back up stall the back end.
// Throughput: one item per cycle while full is low; the square root and the six
// dividers each retire one bit per pipeline stage.
// Reset clears all queues and pipeline valid bits and loads the near-zero
// limit with 429497; no clearing pass follows.
`timescale 1ns / 1ps
`include "radar_measurement_jacobian_assert.svh"

module radar_measurement_jacobian #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [DATA_WIDTH-1:0]          pos_x,
  input  logic signed [DATA_WIDTH-1:0]          pos_y,
  input  logic signed [DATA_WIDTH-1:0]          vel_x,
  input  logic signed [DATA_WIDTH-1:0]          vel_y,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [DATA_WIDTH-1:0]          range_dx,
  output logic signed [DATA_WIDTH-1:0]          range_dy,
  output logic signed [DATA_WIDTH-1:0]          bearing_dx,
  output logic signed [DATA_WIDTH-1:0]          bearing_dy,
  output logic signed [DATA_WIDTH-1:0]          rate_dx,
  output logic signed [DATA_WIDTH-1:0]          rate_dy,
  output logic                                  degenerate,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ramj_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [ramj_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [ramj_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  import ramj_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 6 * W + 4;
  localparam int unsigned OW = 6 * W + 1;

  logic [CFG_DATA_WIDTH-1:0]  near_zero_limit;
  logic [CFG_INDEX_WIDTH-1:0] reg_index;

  logic                       mid_push;
  logic [PW-1:0]              mid_wdata;
  logic                       mid_pop;
  logic [PW-1:0]              mid_rdata;
  logic                       mid_empty;
  logic                       mid_full;
  logic [MID_COUNT_WIDTH-1:0] mid_count;

  logic                       out_push;
  logic [OW-1:0]              out_wdata;
  logic [OW-1:0]              out_rdata;
  logic                       out_full;

  assign reg_index = paddr[CFG_ADDR_WIDTH-1:2];
  assign pready    = 1'b1;
  assign prdata    = (reg_index == REG_NEAR_ZERO_LIMIT) ? near_zero_limit : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= NEAR_ZERO_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_index == REG_NEAR_ZERO_LIMIT)) begin
      near_zero_limit <= pwdata;
    end
  end

  ramj_front #(.DATA_WIDTH(W)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .limit(near_zero_limit), .q_count(mid_count),
    .q_push(mid_push), .q_data(mid_wdata)
  );

  ramj_fifo #(.WIDTH(PW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst), .push(mid_push), .wdata(mid_wdata),
    .pop(mid_pop), .rdata(mid_rdata), .empty(mid_empty), .full(mid_full),
    .count(mid_count)
  );

  ramj_back #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(mid_empty), .q_data(mid_rdata),
    .q_pop(mid_pop), .o_full(out_full), .o_push(out_push), .o_data(out_wdata)
  );

  ramj_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst(rst), .push(out_push), .wdata(out_wdata),
    .pop(pop), .rdata(out_rdata), .empty(empty), .full(out_full),
    .count()
  );

  assign range_dx   = out_rdata[0*W +: W];
  assign range_dy   = out_rdata[1*W +: W];
  assign bearing_dx = out_rdata[2*W +: W];
  assign bearing_dy = out_rdata[3*W +: W];
  assign rate_dx    = out_rdata[4*W +: W];
  assign rate_dy    = out_rdata[5*W +: W];
  assign degenerate = out_rdata[6*W];

  `RMJ_ASSERT_IMPLY(a_mid_credit, mid_push, !mid_full, "middle queue overrun by front end")
  `RMJ_ASSERT_IMPLY(a_degen_zero, !empty && degenerate, (range_dx == '0) && (range_dy == '0) && (bearing_dx == '0) && (bearing_dy == '0) && (rate_dx == '0) && (rate_dy == '0), "degenerate item with non-zero entries")

endmodule
